FILE: rtl/scvp_pkg.sv
package scvp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_CENTER_X = 3'd1,
        REG_CENTER_Y = 3'd2,
        REG_CENTER_Z = 3'd3,
        REG_RADIUS   = 3'd4,
        REG_INV_DT   = 3'd5
    } cfg_index_t;

    localparam logic [30:0] RADIUS_RESET = 31'd1638400;   // 25.0
    localparam logic [31:0] INV_DT_RESET = 32'd1966080;   // 30.0

    // One result bit per stage in the root and quotient units
    localparam int unsigned SQRT_STEPS  = 31;
    localparam int unsigned DIV_STEPS   = 31;
    localparam int unsigned PRE_STAGES  = 3;
    localparam int unsigned POST_STAGES = 5;
    localparam int unsigned SIDE_DEPTH  = SQRT_STEPS + 1 + DIV_STEPS;
    localparam int unsigned PIPE_DEPTH  = PRE_STAGES + SIDE_DEPTH + POST_STAGES;

    typedef logic [2:0][31:0] vec3_t;

    // Vertex data that rides alongside the root and quotient units
    typedef struct packed {
        vec3_t            pos;
        vec3_t            vel;
        logic [2:0]       dneg;
        logic             collide;
        logic [2:0][61:0] rad;
    } side_t;

    // Vertex data that rides through the velocity update
    typedef struct packed {
        vec3_t      pos;
        vec3_t      vel;
        vec3_t      np;
        logic [2:0] dneg;
        logic       collide;
    } post_t;

endpackage

FILE: rtl/scvp_sqrt.sv
module scvp_sqrt
    import scvp_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [61:0] radicand,
    output logic [30:0] root
);

    logic [31:0] rem_reg  [SQRT_STEPS];
    logic [30:0] root_reg [SQRT_STEPS];
    logic [61:0] x_reg    [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [31:0] rem_in;
        logic [30:0] root_in;
        logic [61:0] x_in;
        logic [33:0] t;
        logic [33:0] trial;
        logic [33:0] diff;
        logic [31:0] rem_next;
        logic [30:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = radicand;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
        end

        always_comb begin
            t     = {rem_in, x_in[61:60]};
            trial = {1'b0, root_in, 2'b01};
            diff  = t - trial;
            if (t >= trial) begin
                rem_next  = diff[31:0];
                root_next = {root_in[29:0], 1'b1};
            end else begin
                rem_next  = t[31:0];
                root_next = {root_in[29:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                x_reg[k]    <= {x_in[59:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

FILE: rtl/scvp_div.sv
module scvp_div
    import scvp_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [62:0] num,
    input  logic [30:0] den,
    output logic [30:0] quot
);

    logic [31:0] rem_reg [DIV_STEPS];
    logic [30:0] low_reg [DIV_STEPS];
    logic [30:0] q_reg   [DIV_STEPS];
    logic [30:0] den_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [31:0] rem_in;
        logic [30:0] low_in;
        logic [30:0] q_in;
        logic [30:0] den_in;
        logic [32:0] t;
        logic [32:0] diff;
        logic [31:0] rem_next;
        logic [30:0] q_next;

        if (k == 0) begin : g_first
            assign rem_in = num[62:31];
            assign low_in = num[30:0];
            assign q_in   = '0;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb begin
            t    = {rem_in, low_in[30]};
            diff = t - {2'b00, den_in};
            if (t >= {2'b00, den_in}) begin
                rem_next = diff[31:0];
                q_next   = {q_in[29:0], 1'b1};
            end else begin
                rem_next = t[31:0];
                q_next   = {q_in[29:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_in[29:0], 1'b0};
                q_reg[k]   <= q_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quot = q_reg[DIV_STEPS-1];

endmodule

FILE: rtl/sphere_collision_vertex_projector.sv
// Pipeline from input transaction to result: 3 setup stages, a 31-stage square root,
// one numerator stage, a 31-stage divider and 5 velocity-update stages.
// Throughput: one vertex per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low): drop all in-flight transactions and load the
// configuration registers with their defaults (radius 25.0, inverse step 30.0).
module sphere_collision_vertex_projector
    import scvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pos_x,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_pos_z,
    input  logic [31:0] s_vel_x,
    input  logic [31:0] s_vel_y,
    input  logic [31:0] s_vel_z,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_new_pos_x,
    output logic [31:0] m_new_pos_y,
    output logic [31:0] m_new_pos_z,
    output logic [31:0] m_new_vel_x,
    output logic [31:0] m_new_vel_y,
    output logic [31:0] m_new_vel_z,
    output logic        m_collided,
    output logic        m_saturated
);

    typedef struct packed {
        logic [31:0] val;
        logic        hit;
    } clamp_t;

    // Clamp a wide two's complement value into the signed 32-bit range
    function automatic clamp_t clamp32(input logic [50:0] x);
        clamp_t c;
        c.hit = !((&x[50:31]) || (~|x[50:31]));
        if (c.hit) begin
            c.val = x[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            c.val = x[31:0];
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the
    // pipeline is empty (not enforced here), so every stage reads them directly.
    // ------------------------------------------------------------------
    logic        enable_reg;
    vec3_t       center_reg;
    logic [30:0] radius_reg;
    logic [31:0] inv_dt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            center_reg <= '0;
            radius_reg <= RADIUS_RESET;
            inv_dt_reg <= INV_DT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_ENABLE:   enable_reg    <= cfg_wdata[0];
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_RADIUS:   radius_reg    <= cfg_wdata[30:0];
                REG_INV_DT:   inv_dt_reg    <= cfg_wdata;
                default: ;  // unused index, drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global flow control: every stage advances together unless a finished
    // result is waiting on the output.
    // ------------------------------------------------------------------
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign adv     = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from the centre, magnitude, per-axis inside test.
    // ------------------------------------------------------------------
    vec3_t            in_pos;
    vec3_t            in_vel;
    logic [2:0][32:0] d;
    logic [2:0][32:0] ad;
    logic [2:0]       lt;

    assign in_pos = {s_pos_z, s_pos_y, s_pos_x};
    assign in_vel = {s_vel_z, s_vel_y, s_vel_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i]  = {in_pos[i][31], in_pos[i]} - {center_reg[i][31], center_reg[i]};
            ad[i] = d[i][32] ? (~d[i] + 33'd1) : d[i];
            lt[i] = ad[i] < {2'b00, radius_reg};
        end
    end

    vec3_t            st1_pos_reg;
    vec3_t            st1_vel_reg;
    logic [2:0]       st1_dneg_reg;
    logic [2:0][30:0] st1_ad_reg;
    logic             st1_inside_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_pos_reg    <= in_pos;
            st1_vel_reg    <= in_vel;
            st1_inside_reg <= enable_reg && (&lt);
            for (int i = 0; i < 3; i++) begin
                st1_dneg_reg[i] <= d[i][32];
                st1_ad_reg[i]   <= ad[i][30:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares, velocity-offset products, r*|d| and r^2.
    // ------------------------------------------------------------------
    logic [2:0][31:0] vmag;
    logic [2:0][61:0] sq_next;
    logic [2:0][62:0] vd_next;
    logic [2:0][61:0] rad_next;
    logic [61:0]      rr_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vmag[i]     = st1_vel_reg[i][31] ? (~st1_vel_reg[i] + 32'd1) : st1_vel_reg[i];
            sq_next[i]  = {31'b0, st1_ad_reg[i]} * {31'b0, st1_ad_reg[i]};
            vd_next[i]  = {31'b0, vmag[i]} * {32'b0, st1_ad_reg[i]};
            rad_next[i] = {31'b0, radius_reg} * {31'b0, st1_ad_reg[i]};
        end
        rr_next = {31'b0, radius_reg} * {31'b0, radius_reg};
    end

    vec3_t            st2_pos_reg;
    vec3_t            st2_vel_reg;
    logic [2:0]       st2_dneg_reg;
    logic             st2_inside_reg;
    logic [2:0][61:0] st2_sq_reg;
    logic [2:0][62:0] st2_vd_reg;
    logic [2:0]       st2_neg_reg;
    logic [2:0][61:0] st2_rad_reg;
    logic [61:0]      st2_rr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_pos_reg    <= st1_pos_reg;
            st2_vel_reg    <= st1_vel_reg;
            st2_dneg_reg   <= st1_dneg_reg;
            st2_inside_reg <= st1_inside_reg;
            st2_sq_reg     <= sq_next;
            st2_vd_reg     <= vd_next;
            st2_rad_reg    <= rad_next;
            st2_rr_reg     <= rr_next;
            for (int i = 0; i < 3; i++) begin
                st2_neg_reg[i] <= st1_vel_reg[i][31] ^ st1_dneg_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance and the split dot product.
    // ------------------------------------------------------------------
    logic [63:0] sum_next;
    logic [63:0] dneg_sum_next;
    logic [63:0] dpos_sum_next;

    always_comb begin
        sum_next      = {2'b0, st2_sq_reg[0]} + {2'b0, st2_sq_reg[1]} + {2'b0, st2_sq_reg[2]};
        dneg_sum_next = '0;
        dpos_sum_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (st2_neg_reg[i]) begin
                dneg_sum_next = dneg_sum_next + {1'b0, st2_vd_reg[i]};
            end else begin
                dpos_sum_next = dpos_sum_next + {1'b0, st2_vd_reg[i]};
            end
        end
    end

    vec3_t            st3_pos_reg;
    vec3_t            st3_vel_reg;
    logic [2:0]       st3_dneg_reg;
    logic             st3_inside_reg;
    logic [2:0][61:0] st3_rad_reg;
    logic [61:0]      st3_rr_reg;
    logic [63:0]      st3_sum_reg;
    logic [63:0]      st3_dneg_sum_reg;
    logic [63:0]      st3_dpos_sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_pos_reg      <= st2_pos_reg;
            st3_vel_reg      <= st2_vel_reg;
            st3_dneg_reg     <= st2_dneg_reg;
            st3_inside_reg   <= st2_inside_reg;
            st3_rad_reg      <= st2_rad_reg;
            st3_rr_reg       <= st2_rr_reg;
            st3_sum_reg      <= sum_next;
            st3_dneg_sum_reg <= dneg_sum_next;
            st3_dpos_sum_reg <= dpos_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Collision decision enters the side line together with the radicand
    // entering the root unit. A vertex at the exact centre has zero sum
    // and never collides, so the divisor below is never zero when used.
    // ------------------------------------------------------------------
    side_t side_next;
    side_t side_reg [SIDE_DEPTH];

    always_comb begin
        side_next.pos     = st3_pos_reg;
        side_next.vel     = st3_vel_reg;
        side_next.dneg    = st3_dneg_reg;
        side_next.rad     = st3_rad_reg;
        side_next.collide = st3_inside_reg && (st3_sum_reg != 64'd0)
                            && (st3_sum_reg < {2'b00, st3_rr_reg})
                            && (st3_dneg_sum_reg > st3_dpos_sum_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Length of the offset, floor(sqrt(sum))
    logic [30:0] len;

    scvp_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (st3_sum_reg[61:0]),
        .root     (len)
    );

    // Numerator for the rounded quotient r*|d|/len
    logic [2:0][62:0] num_reg;
    logic [30:0]      den_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg <= len;
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= {1'b0, side_reg[SQRT_STEPS-1].rad[i]} + {33'b0, len[30:1]};
            end
        end
    end

    logic [2:0][30:0] quot;

    for (genvar i = 0; i < 3; i++) begin : g_div
        scvp_div u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (num_reg[i]),
            .den  (den_reg),
            .quot (quot[i])
        );
    end

    // ------------------------------------------------------------------
    // Post 1: surface point = centre +/- quotient, clamped.
    // ------------------------------------------------------------------
    side_t            side_out;
    post_t            post1_next;
    logic [2:0][50:0] np_wide;
    clamp_t [2:0]     np_clamp;

    assign side_out = side_reg[SIDE_DEPTH-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            np_wide[i]  = {{19{center_reg[i][31]}}, center_reg[i]}
                          + (side_out.dneg[i] ? (~{20'b0, quot[i]} + 51'd1)
                                              : {20'b0, quot[i]});
            np_clamp[i] = clamp32(np_wide[i]);
        end
        post1_next.pos     = side_out.pos;
        post1_next.vel     = side_out.vel;
        post1_next.dneg    = side_out.dneg;
        post1_next.collide = side_out.collide;
        for (int i = 0; i < 3; i++) begin
            post1_next.np[i] = np_clamp[i].val;
        end
    end

    post_t post_reg [POST_STAGES-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            post_reg[0] <= post1_next;
            for (int k = 1; k < POST_STAGES - 1; k++) begin
                post_reg[k] <= post_reg[k-1];
            end
        end
    end

    // Post 2: position change, split into sign and magnitude
    logic [2:0][32:0] off;
    logic [2:0][31:0] omag_reg;
    logic [2:0]       oneg_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            off[i] = {post_reg[0].np[i][31], post_reg[0].np[i]}
                     - {post_reg[0].pos[i][31], post_reg[0].pos[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                oneg_reg[i] <= off[i][32];
                omag_reg[i] <= off[i][32] ? 32'(~off[i] + 33'd1) : off[i][31:0];
            end
        end
    end

    // Post 3: scale by the inverse time step
    logic [2:0][63:0] prod_reg;
    logic [2:0]       oneg3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            oneg3_reg <= oneg_reg;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= {32'b0, omag_reg[i]} * {32'b0, inv_dt_reg};
            end
        end
    end

    // Post 4: round half up back to Q16.16
    logic [2:0][64:0] rnd;
    logic [2:0][48:0] inc_reg;
    logic [2:0]       oneg4_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = {1'b0, prod_reg[i]} + 65'd32768;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oneg4_reg <= oneg3_reg;
            for (int i = 0; i < 3; i++) begin
                inc_reg[i] <= rnd[i][64:16];
            end
        end
    end

    // Post 5: apply the increment with saturation, pick the result
    post_t            pl;
    logic [2:0][50:0] nv_wide;
    clamp_t [2:0]     nv_clamp;
    vec3_t            out_pos;
    vec3_t            out_vel;
    logic             out_sat;

    assign pl = post_reg[POST_STAGES-2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nv_wide[i]  = oneg4_reg[i]
                          ? ({{19{pl.vel[i][31]}}, pl.vel[i]} - {2'b0, inc_reg[i]})
                          : ({{19{pl.vel[i][31]}}, pl.vel[i]} + {2'b0, inc_reg[i]});
            nv_clamp[i] = clamp32(nv_wide[i]);
            out_pos[i]  = pl.collide ? pl.np[i] : pl.pos[i];
            out_vel[i]  = pl.collide ? nv_clamp[i].val : pl.vel[i];
        end
        out_sat = pl.collide && (nv_clamp[0].hit || nv_clamp[1].hit || nv_clamp[2].hit);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_new_pos_x <= out_pos[0];
            m_new_pos_y <= out_pos[1];
            m_new_pos_z <= out_pos[2];
            m_new_vel_x <= out_vel[0];
            m_new_vel_y <= out_vel[1];
            m_new_vel_z <= out_vel[2];
            m_collided  <= pl.collide;
            m_saturated <= out_sat;
        end
    end

endmodule
